[hdl/pat_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants of the paged address translator
// ----------------------------------------------------------------------------
package pat_pkg;

    // sizing of the translator
    localparam int PROCESSORS       = 4;
    localparam int PAGE_BYTES       = 512;
    localparam int CODE_SPACE_BYTES = 512;
    localparam int DATA_SPACE_BYTES = 4096;
    localparam int LOGICAL_PAGES    = 9;
    localparam int PHYSICAL_PAGES   = 16;

    localparam int CODE_PAGES = (CODE_SPACE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int DATA_PAGE_LIMIT = (DATA_SPACE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int PROC_W    = 3;
    localparam int ADDR_W    = 13;
    localparam int SIZE_W    = 13;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 5;

    localparam int S_TDATA_W = ((PROC_W + ADDR_W + 2 * SIZE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + 1 + CNT_OUT_W + 7) / 8) * 8;

    // derived widths
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PPN_W       = $clog2(PHYSICAL_PAGES);
    localparam int MAP_DEPTH   = PROCESSORS * LOGICAL_PAGES;
    localparam int MAP_IDX_W   = $clog2(MAP_DEPTH);
    localparam int LP_W        = $clog2(LOGICAL_PAGES);
    localparam int USED_CNT_W  = $clog2(PHYSICAL_PAGES + 1);
    localparam int PAGES_SAT   = (1 << CNT_OUT_W) - 1;

    typedef enum logic [FUNC_W-1:0] {
        OP_FETCH   = 2'd0,
        OP_DATA    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_MAP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_PROC  = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_NO_PAGE   = 3'd3,
        STAT_UNMAPPED  = 3'd4,
        STAT_TOO_LARGE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_REL_READ,
        S_REL_CLEAR,
        S_ALLOC,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    lookup_commit;
        logic    walk_start;
        logic    rel_read;
        logic    rel_clear;
        logic    alloc;
        logic    finish;
        status_t finish_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic pre_err;
        logic walk_last;
        logic alloc_fail;
        logic alloc_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

[hdl/pat_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer for translations, page table walks and page allocation
// ----------------------------------------------------------------------------
module pat_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire pat_pkg::dp_stat_t stat,
    output pat_pkg::ctrl_cmd_t     cmd
);
    import pat_pkg::*;

    state_t state_reg, state_next;
    logic   rollback_reg, rollback_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rollback_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rollback_reg <= rollback_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        rollback_next     = rollback_reg;
        cmd               = '0;
        cmd.finish_status = rollback_reg ? STAT_NO_PAGE : STAT_OK;
        s_tready          = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept    = 1'b1;
                    rollback_next = 1'b0;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (stat.pre_err || stat.op == OP_FETCH || stat.op == OP_DATA) begin
                    if (stat.out_free) begin
                        cmd.lookup_commit = 1'b1;
                        state_next        = S_IDLE;
                    end
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_REL_READ;
                end
            end
            S_REL_READ: begin
                cmd.rel_read = 1'b1;
                state_next   = S_REL_CLEAR;
            end
            S_REL_CLEAR: begin
                cmd.rel_clear = 1'b1;
                if (stat.walk_last) begin
                    if (stat.op == OP_MAP && !rollback_reg) begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_ALLOC;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_REL_READ;
                end
            end
            S_ALLOC: begin
                if (stat.alloc_fail) begin
                    // pool exhausted: undo the partial mapping
                    rollback_next  = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = S_REL_READ;
                end else begin
                    cmd.alloc = 1'b1;
                    if (stat.alloc_last) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/pat_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pat_datapath
// Page table memory, used-page bitmap, free page search and result register
// ----------------------------------------------------------------------------
module pat_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pat_pkg::op_t                  in_func,
    input  wire logic [pat_pkg::PROC_W-1:0]    in_processor,
    input  wire logic [pat_pkg::ADDR_W-1:0]    in_address,
    input  wire logic [pat_pkg::SIZE_W-1:0]    in_code_bytes,
    input  wire logic [pat_pkg::SIZE_W-1:0]    in_data_size,
    input  wire pat_pkg::ctrl_cmd_t            cmd,
    output pat_pkg::dp_stat_t                  stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pat_pkg::ADDR_W-1:0]         phys_addr,
    output pat_pkg::status_t                   status,
    output logic                               demand_mapped,
    output logic [pat_pkg::CNT_OUT_W-1:0]      pages_in_use
);
    import pat_pkg::*;

    function automatic logic [SIZE_W:0] pages_needed(input logic [SIZE_W-1:0] bytes);
        logic [SIZE_W:0] sum;
        sum = {1'b0, bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
        if (bytes == '0) begin
            return (SIZE_W+1)'(1);
        end
        return sum >> PAGE_SHIFT;
    endfunction

    // page table and bitmap
    logic [PPN_W-1:0]      map_mem [MAP_DEPTH];
    logic [PPN_W-1:0]      rdata_reg;
    logic [MAP_DEPTH-1:0]  map_valid_reg, map_valid_next;
    logic [PHYSICAL_PAGES-1:0] used_reg, used_next;
    logic [USED_CNT_W-1:0] used_cnt_reg, used_cnt_next;

    // item registers
    op_t                   op_reg;
    logic                  fetch_reg;
    logic [PAGE_SHIFT-1:0] offset_reg;
    logic [MAP_IDX_W-1:0]  idx_reg;
    logic [MAP_IDX_W-1:0]  base_reg;
    logic [LP_W-1:0]       cp_reg;
    status_t               pre_status_reg;
    logic [LP_W-1:0]       walk_idx_reg;

    // result register
    logic                  m_tvalid_reg;
    logic [ADDR_W-1:0]     phys_reg;
    status_t               status_reg;
    logic                  demand_reg;
    logic [CNT_OUT_W-1:0]  pages_reg;

    // accept-time decode
    logic                  in_fetch;
    logic [ADDR_W:0]       in_lp;
    logic                  in_range_err;
    logic [SIZE_W:0]       in_cp;
    logic [SIZE_W:0]       in_dp;
    logic                  in_too_large;
    status_t               in_pre_status;
    logic [MAP_IDX_W-1:0]  in_idx;
    logic [MAP_IDX_W-1:0]  in_base;

    // lookup and walk
    logic [PPN_W-1:0]      free_page;
    logic                  any_free;
    logic                  hit;
    status_t               lk_status;
    logic                  lk_demand;
    logic [PPN_W-1:0]      lk_page;
    logic [ADDR_W-1:0]     lk_phys;
    logic [MAP_IDX_W-1:0]  walk_addr;
    logic [LP_W-1:0]       alloc_lp;
    logic [MAP_IDX_W-1:0]  alloc_addr;
    logic                  take;
    logic                  clr;
    logic                  mem_we;
    logic [MAP_IDX_W-1:0]  mem_waddr;
    logic                  mem_re;
    logic [MAP_IDX_W-1:0]  mem_raddr;
    logic                  load_out;
    logic                  out_free;

    localparam logic CODE_NO_DATA = (CODE_PAGES >= LOGICAL_PAGES);

    always_comb begin
        in_fetch     = (in_func == OP_FETCH);
        in_lp        = {1'b0, in_address >> PAGE_SHIFT}
                     + (in_fetch ? '0 : (ADDR_W+1)'(CODE_PAGES));
        in_range_err = (in_fetch ? ({1'b0, in_address} >= (ADDR_W+1)'(CODE_SPACE_BYTES))
                                 : ({1'b0, in_address} >= (ADDR_W+1)'(DATA_SPACE_BYTES)))
                     || (in_lp >= (ADDR_W+1)'(LOGICAL_PAGES));
        in_cp        = pages_needed(in_code_bytes);
        in_dp        = pages_needed(in_data_size);
        in_too_large = (in_cp > (SIZE_W+1)'(CODE_PAGES))
                     || (in_dp > (SIZE_W+1)'(DATA_PAGE_LIMIT))
                     || CODE_NO_DATA;
        in_base      = MAP_IDX_W'(int'(in_processor) * LOGICAL_PAGES);
        in_idx       = MAP_IDX_W'(int'(in_processor) * LOGICAL_PAGES + int'(in_lp));
        if ({1'b0, in_processor} >= (PROC_W+1)'(PROCESSORS)) begin
            in_pre_status = STAT_BAD_PROC;
        end else begin
            case (in_func) inside
                OP_FETCH, OP_DATA: in_pre_status = in_range_err ? STAT_RANGE : STAT_OK;
                OP_MAP:            in_pre_status = in_too_large ? STAT_TOO_LARGE : STAT_OK;
                default:           in_pre_status = STAT_OK;
            endcase
        end
    end

    // lowest free physical page
    always_comb begin
        free_page = '0;
        any_free  = 1'b0;
        for (int i = PHYSICAL_PAGES - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_page = PPN_W'(i);
                any_free  = 1'b1;
            end
        end
    end

    always_comb begin
        hit       = map_valid_reg[idx_reg];
        lk_demand = 1'b0;
        if (pre_status_reg != STAT_OK) begin
            lk_status = pre_status_reg;
        end else if (hit) begin
            lk_status = STAT_OK;
        end else if (fetch_reg) begin
            lk_status = STAT_UNMAPPED;
        end else if (any_free) begin
            lk_status = STAT_OK;
            lk_demand = 1'b1;
        end else begin
            lk_status = STAT_NO_PAGE;
        end
        lk_page = hit ? rdata_reg : free_page;
        lk_phys = (lk_status == STAT_OK) ? ADDR_W'({lk_page, offset_reg}) : '0;
    end

    always_comb begin
        walk_addr  = MAP_IDX_W'(int'(base_reg) + int'(walk_idx_reg));
        alloc_lp   = (walk_idx_reg < cp_reg) ? walk_idx_reg : LP_W'(CODE_PAGES);
        alloc_addr = MAP_IDX_W'(int'(base_reg) + int'(alloc_lp));
        out_free   = !m_tvalid_reg || m_tready;
        load_out   = cmd.lookup_commit || cmd.finish;

        map_valid_next = map_valid_reg;
        used_next      = used_reg;
        take           = 1'b0;
        clr            = 1'b0;
        if (cmd.lookup_commit && lk_demand) begin
            take                    = 1'b1;
            used_next[free_page]    = 1'b1;
            map_valid_next[idx_reg] = 1'b1;
        end
        if (cmd.rel_clear) begin
            if (map_valid_reg[walk_addr]) begin
                clr                  = 1'b1;
                used_next[rdata_reg] = 1'b0;
            end
            map_valid_next[walk_addr] = 1'b0;
        end
        if (cmd.alloc && any_free) begin
            take                       = 1'b1;
            used_next[free_page]       = 1'b1;
            map_valid_next[alloc_addr] = 1'b1;
        end
        used_cnt_next = used_cnt_reg + USED_CNT_W'(take) - USED_CNT_W'(clr);

        mem_we    = take;
        mem_waddr = cmd.lookup_commit ? idx_reg : alloc_addr;
        mem_re    = cmd.accept || cmd.rel_read;
        mem_raddr = cmd.accept ? in_idx : walk_addr;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= free_page;
        end
        if (mem_re) begin
            rdata_reg <= map_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= '0;
            used_reg      <= '0;
            used_cnt_reg  <= '0;
            walk_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            map_valid_reg <= map_valid_next;
            used_reg      <= used_next;
            used_cnt_reg  <= used_cnt_next;
            if (cmd.walk_start) begin
                walk_idx_reg <= '0;
            end else if (cmd.rel_clear || cmd.alloc) begin
                walk_idx_reg <= walk_idx_reg + LP_W'(1);
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg         <= in_func;
            fetch_reg      <= in_fetch;
            offset_reg     <= in_address[PAGE_SHIFT-1:0];
            idx_reg        <= in_idx;
            base_reg       <= in_base;
            cp_reg         <= LP_W'(in_cp);
            pre_status_reg <= in_pre_status;
        end
        if (load_out) begin
            if (cmd.lookup_commit) begin
                phys_reg   <= lk_phys;
                status_reg <= lk_status;
                demand_reg <= lk_demand;
            end else begin
                phys_reg   <= '0;
                status_reg <= cmd.finish_status;
                demand_reg <= 1'b0;
            end
            pages_reg <= (int'(used_cnt_next) > PAGES_SAT) ? CNT_OUT_W'(PAGES_SAT)
                                                          : CNT_OUT_W'(used_cnt_next);
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.pre_err    = (pre_status_reg != STAT_OK);
        stat.walk_last  = (walk_idx_reg == LP_W'(LOGICAL_PAGES - 1));
        stat.alloc_fail = !any_free;
        stat.alloc_last = (walk_idx_reg == cp_reg);
        stat.out_free   = out_free;
    end

    assign m_tvalid      = m_tvalid_reg;
    assign phys_addr     = phys_reg;
    assign status        = status_reg;
    assign demand_mapped = demand_reg;
    assign pages_in_use  = pages_reg;

`ifndef ASSERT_OFF
    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(used_cnt_reg) == $countones(used_reg))
        else $error("used page count out of step with bitmap");

    a_mapped_is_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rel_clear && map_valid_reg[walk_addr]) |-> used_reg[rdata_reg])
        else $error("mapped entry points at a free page");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result loaded over a pending transfer");

    a_alloc_has_page: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |-> any_free)
        else $error("allocation with empty pool");
`endif

endmodule
`default_nettype wire

[hdl/paged_address_translator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paged_address_translator
// Per-processor page tables over a shared physical page pool
// ----------------------------------------------------------------------------
// A fetch or data translation first reads the page table memory into a
// register, then checks the entry and, for a data access to an unmapped page,
// takes the lowest free page. A release walks the processor's nine table
// entries, reading and then clearing each one. A map runs the same walk,
// then allocates one page a cycle for the code pages and the first data page;
// on an exhausted pool it walks the table once more to roll back. The block
// takes a new item only when the previous one has finished its work; a result
// waiting in the output register does not hold off the next input transfer.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module paged_address_translator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // processor, address, code_bytes, data_size
    input  wire logic [pat_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  wire logic [pat_pkg::FUNC_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // phys_addr, demand_mapped, pages_in_use
    output logic [pat_pkg::M_TDATA_W-1:0]        m_tdata,
    // status
    output logic [pat_pkg::STATUS_W-1:0]         m_tuser
);
    import pat_pkg::*;

    ctrl_cmd_t             cmd;
    dp_stat_t              stat;
    logic [ADDR_W-1:0]     phys_addr;
    status_t               status;
    logic                  demand_mapped;
    logic [CNT_OUT_W-1:0]  pages_in_use;

    pat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pat_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_func          (op_t'(s_tuser)),
        .in_processor     (s_tdata[PROC_W-1:0]),
        .in_address       (s_tdata[PROC_W +: ADDR_W]),
        .in_code_bytes    (s_tdata[PROC_W + ADDR_W +: SIZE_W]),
        .in_data_size     (s_tdata[PROC_W + ADDR_W + SIZE_W +: SIZE_W]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .phys_addr        (phys_addr),
        .status           (status),
        .demand_mapped    (demand_mapped),
        .pages_in_use     (pages_in_use)
    );

    assign m_tdata = M_TDATA_W'({pages_in_use, demand_mapped, phys_addr});
    assign m_tuser = status;

endmodule
`default_nettype wire
